// ===== sv/catmull_rom_keyframe_interpolator_macros.svh =====
// Assertion macros used by the checker file.
`ifndef CATMULL_ROM_KEYFRAME_INTERPOLATOR_MACROS_SVH
`define CATMULL_ROM_KEYFRAME_INTERPOLATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CRKI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CRKI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/crki_pkg.sv =====
package crki_pkg;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IN_TDATA_W = 168;
  localparam int unsigned OUT_TDATA_W = 96;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
endpackage

// ===== sv/catmull_rom_keyframe_interpolator.sv =====
// Write beats are stored as they are taken; the block stays idle, ready for the next beat.
// Query beats: segment i is searched (i at most N-1) and interpolated before out_tvalid;
// modulo skipped when the last time is zero; with at most one keyframe, no search at all.
// Work runs through the serial modulo/divide (one bit a cycle) and the shared
// 48 x (FRAC_BITS+1) multiply. A result sits in the output register until taken;
// the next beat can be taken in the cycle after. Reset (rst_n low, synchronous) clears the control state and kcount_r.
module catmull_rom_keyframe_interpolator
  import crki_pkg::*;
#(
  parameter int unsigned MAX_KEYFRAMES = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // op[0], entry_index[6:1], key_time[38:7], key_x[70:39], key_y[102:71],
  // key_z[134:103], query_time[166:135], zero pad [167]
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [6:0] cfg_wdata
);
  localparam int unsigned AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYFRAMES + 1);
  localparam int unsigned NUMW = 32 + FRAC_BITS;
  localparam int unsigned CNTW = $clog2(NUMW + 1);
  localparam int unsigned AX = 48;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_LAST  = 15'h0002,
    S_LASTW = 15'h0004,
    S_MOD   = 15'h0008,
    S_SRCH  = 15'h0010,
    S_SRCHW = 15'h0020,
    S_T0    = 15'h0040,
    S_DIV   = 15'h0080,
    S_PRD   = 15'h0100,
    S_PRW   = 15'h0200,
    S_COEF  = 15'h0400,
    S_MUL   = 15'h0800,
    S_ACC   = 15'h1000,
    S_FIN   = 15'h2000,
    S_OUT   = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] t_mem [MAX_KEYFRAMES];
  logic [31:0] x_mem [MAX_KEYFRAMES];
  logic [31:0] y_mem [MAX_KEYFRAMES];
  logic [31:0] z_mem [MAX_KEYFRAMES];
  logic [AW-1:0] raddr;
  logic [31:0] t_rd_r, x_rd_r, y_rd_r, z_rd_r;

  logic [CW-1:0] kcount_r;
  logic [CW-1:0] n_eff;

  logic in_fire;
  logic in_op;
  logic [5:0] in_idx;
  assign in_fire = in_tvalid && in_tready;
  assign in_op = in_tdata[0];
  assign in_idx = in_tdata[6:1];
  assign in_tready = (state_r == S_IDLE) && !out_tvalid;

  function automatic logic cfg_fit(input logic [CW-1:0] v);
    cfg_fit = (32'(v) <= MAX_KEYFRAMES);
  endfunction
  assign n_eff = (cfg_fit(kcount_r)) ? kcount_r : CW'(MAX_KEYFRAMES);

  // Work registers
  logic [31:0] q_r, last_r, t0_r, t1_r;
  logic [CW-1:0] i_r;
  logic [NUMW-1:0] rem_r, num_r;
  logic [NUMW-1:0] quo_r;
  logic [CNTW-1:0] cnt_r;
  logic [FRAC_BITS:0] u_r;
  logic [1:0] pk_r;
  logic [1:0] ax_r;
  logic signed [33:0] p_r [3][4];
  logic signed [36:0] c_r [4];
  logic signed [AX-1:0] a_r;
  logic [1:0] hs_r;
  logic signed [AX+FRAC_BITS+1:0] prod_r;
  logic [31:0] res_r [3];

  always_comb begin
    raddr = '0;
    case (state_r)
      S_IDLE:  raddr = '0;
      S_LAST:  raddr = AW'(n_eff - 1'b1);
      S_SRCH:  raddr = AW'(i_r);
      S_T0:    raddr = AW'(i_r - 1'b1);
      S_PRD: begin
        case (pk_r)
          2'd0: raddr = (i_r >= 2) ? AW'(i_r - 2'd2) : AW'(i_r - 1'b1);
          2'd1: raddr = AW'(i_r - 1'b1);
          2'd2: raddr = AW'(i_r);
          default: raddr = (32'(i_r) + 1 < 32'(n_eff)) ? AW'(i_r + 1'b1) : AW'(i_r);
        endcase
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_WRITE && 32'(in_idx) < MAX_KEYFRAMES) begin
      t_mem[AW'(in_idx)] <= in_tdata[38:7];
      x_mem[AW'(in_idx)] <= in_tdata[70:39];
      y_mem[AW'(in_idx)] <= in_tdata[102:71];
      z_mem[AW'(in_idx)] <= in_tdata[134:103];
    end
    t_rd_r <= t_mem[raddr];
    x_rd_r <= x_mem[raddr];
    y_rd_r <= y_mem[raddr];
    z_rd_r <= z_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) kcount_r <= '0;
    else if (cfg_we) kcount_r <= (32'(cfg_wdata) > MAX_KEYFRAMES) ?
      CW'(MAX_KEYFRAMES) : CW'(cfg_wdata);
  end

  // Divider step (restoring, one bit per cycle)
  logic [NUMW:0] trial;
  logic [NUMW-1:0] rem_sh;
  logic [31:0] den;
  assign den = (state_r == S_MOD) ? last_r : (t1_r - t0_r);
  assign rem_sh = {rem_r[NUMW-2:0], num_r[NUMW-1]};
  assign trial = {1'b0, rem_sh} - {{(NUMW-31){1'b0}}, den};

  // Multiplier: a * u, rounded
  logic signed [AX+FRAC_BITS+1:0] mul_w;
  assign mul_w = a_r * $signed({1'b0, u_r});
  logic signed [AX+FRAC_BITS+1:0] rnd_w;
  assign rnd_w = (prod_r + (AX+FRAC_BITS+2)'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;

  logic signed [AX-1:0] fin_w;
  assign fin_w = (a_r + 1) >>> 1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire && in_op == OP_QUERY) begin
        if (n_eff <= 1) state_nxt = S_LASTW; else state_nxt = S_LAST;
      end
      S_LAST:  state_nxt = S_LASTW;
      S_LASTW: state_nxt = (n_eff <= 1) ? S_OUT : S_MOD;
      S_MOD:   if (last_r == 0 || cnt_r == CNTW'(32)) state_nxt = S_SRCH;
      S_SRCH:  state_nxt = S_SRCHW;
      S_SRCHW: if (q_r < t_rd_r || i_r == n_eff - 1'b1) state_nxt = S_T0;
        else state_nxt = S_SRCH;
      S_T0:    state_nxt = S_DIV;
      S_DIV:   if (cnt_r == CNTW'(NUMW + 2)) state_nxt = S_PRD;
      S_PRD:   state_nxt = S_PRW;
      S_PRW:   state_nxt = (pk_r == 2'd3) ? S_COEF : S_PRD;
      S_COEF:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = (hs_r == 2'd2) ? S_FIN : S_MUL;
      S_FIN:   state_nxt = (ax_r == 2'd2) ? S_OUT : S_COEF;
      S_OUT:   if (out_tvalid && out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      else if (state_r == S_LASTW && n_eff <= 1) out_tvalid <= 1'b1;
      else if (state_r == S_FIN && ax_r == 2'd2) out_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        q_r <= in_tdata[166:135];
        cnt_r <= '0;
        ax_r <= '0;
        pk_r <= '0;
      end
      S_LASTW: begin
        if (n_eff == 0) begin
          res_r[0] <= '0; res_r[1] <= '0; res_r[2] <= '0;
        end else begin
          res_r[0] <= x_rd_r; res_r[1] <= y_rd_r; res_r[2] <= z_rd_r;
        end
        last_r <= t_rd_r;
        num_r <= {q_r, {FRAC_BITS{1'b0}}};
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_MOD: begin
        // q mod last: 32 quotient steps over the top of num_r
        if (last_r == 0) begin
          q_r <= '0;
        end else if (cnt_r == CNTW'(32)) begin
          q_r <= rem_r[31:0];
        end else begin
          rem_r <= trial[NUMW] ? rem_sh : trial[NUMW-1:0];
          num_r <= num_r << 1;
          cnt_r <= cnt_r + 1'b1;
        end
        i_r <= CW'(1);
      end
      S_SRCHW: begin
        if (!(q_r < t_rd_r || i_r == n_eff - 1'b1)) i_r <= i_r + 1'b1;
        t1_r <= t_rd_r;
      end
      S_T0: cnt_r <= '0;
      S_DIV: begin
        if (cnt_r == 0) begin
          t0_r <= t_rd_r;
          cnt_r <= cnt_r + 1'b1;
        end else if (cnt_r == 1) begin
          num_r <= {q_r - t0_r, {FRAC_BITS{1'b0}}};
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= cnt_r + 1'b1;
        end else if (cnt_r == CNTW'(NUMW + 2)) begin
          if (t1_r > t0_r && q_r > t0_r)
            u_r <= (quo_r > NUMW'(1 << FRAC_BITS)) ? (FRAC_BITS+1)'(1 << FRAC_BITS)
              : quo_r[FRAC_BITS:0];
          else u_r <= '0;
        end else begin
          rem_r <= trial[NUMW] ? rem_sh : trial[NUMW-1:0];
          quo_r <= {quo_r[NUMW-2:0], ~trial[NUMW]};
          num_r <= num_r << 1;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      S_PRW: begin
        p_r[0][pk_r] <= 34'(signed'(x_rd_r));
        p_r[1][pk_r] <= 34'(signed'(y_rd_r));
        p_r[2][pk_r] <= 34'(signed'(z_rd_r));
        pk_r <= pk_r + 1'b1;
      end
      S_COEF: begin
        c_r[0] <= 37'(p_r[ax_r][1]) <<< 1;
        c_r[1] <= 37'(p_r[ax_r][2]) - 37'(p_r[ax_r][0]);
        c_r[2] <= (37'(p_r[ax_r][0]) <<< 1) - 37'(p_r[ax_r][1]) * 5
          + (37'(p_r[ax_r][2]) <<< 2) - 37'(p_r[ax_r][3]);
        a_r <= AX'(-37'(p_r[ax_r][0]) + 37'(p_r[ax_r][1]) * 3
          - 37'(p_r[ax_r][2]) * 3 + 37'(p_r[ax_r][3]));
        hs_r <= '0;
      end
      S_MUL: prod_r <= mul_w;
      S_ACC: begin
        case (hs_r)
          2'd0: a_r <= AX'(rnd_w) + AX'(c_r[2]);
          2'd1: a_r <= AX'(rnd_w) + AX'(c_r[1]);
          default: a_r <= AX'(rnd_w) + AX'(c_r[0]);
        endcase
        hs_r <= hs_r + 1'b1;
      end
      S_FIN: begin
        if (fin_w > 48'sd2147483647) res_r[ax_r] <= 32'h7fffffff;
        else if (fin_w < -48'sd2147483648) res_r[ax_r] <= 32'h80000000;
        else res_r[ax_r] <= fin_w[31:0];
        ax_r <= ax_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_tdata = {res_r[2], res_r[1], res_r[0]};
endmodule

// ===== sv/crki_checker.sv =====
`include "catmull_rom_keyframe_interpolator_macros.svh"
module crki_checker
  import crki_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);
  `CRKI_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped while stalled")
  `CRKI_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_tvalid, !in_tready, "input taken while result pending")
  `CRKI_ASSERT_NXT(a_query_busy, clk, rst_n, in_tvalid && in_tready, !out_tvalid, "result without work cycle")
endmodule

bind catmull_rom_keyframe_interpolator crki_checker u_crki_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
